// File: design/ray_segment_box_slab_test_defines.svh
// Assertion macros used by the segment/box slab tester checker.
// Both macros expect clk and arst_n to be visible where they are used.
`ifndef RAY_SEGMENT_BOX_SLAB_TEST_DEFINES_SVH
`define RAY_SEGMENT_BOX_SLAB_TEST_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define RSB_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed");

// Next-cycle implication, checked outside reset
`define RSB_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

// File: design/rsbst_pkg.sv
// Shared types and constants for the segment/box slab tester.
// No dependencies.
package rsbst_pkg;

	// Width of a t value and of its magnitude
	localparam int T_W       = 48;
	localparam int MAG_W     = T_W - 1;
	localparam int NUM_AXES  = 3;
	localparam int NUM_LANES = 2 * NUM_AXES;
	localparam int OUT_W     = 8;

	localparam logic [T_W-1:0] T_SAT_POS = {1'b0, {MAG_W{1'b1}}};
	localparam logic [T_W-1:0] T_SAT_NEG = {1'b1, {MAG_W{1'b0}}};

	// Per-axis flags for the zero-direction case
	typedef struct packed {
		logic zero;     // direction component is zero
		logic in_slab;  // origin lies within the slab
	} rsbst_axis_t;

	// Per-quotient control travelling with the divider
	typedef struct packed {
		logic neg;     // quotient is negative
		logic sat;     // quotient saturates
	} rsbst_qctl_t;

endpackage

// File: design/rsbst_prep.sv
// Front end: slab offsets, magnitudes, signs and saturation detect (two stages).
// Depends on rsbst_pkg.
module rsbst_prep #(
	parameter int COORD_WIDTH   = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic clk,
	input  logic en,
	input  logic [rsbst_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0] origin,
	input  logic [rsbst_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0] delta,
	input  logic [rsbst_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0] box_min,
	input  logic [rsbst_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0] box_max,
	output logic [rsbst_pkg::NUM_LANES-1:0][COORD_WIDTH:0]  num_mag,
	output logic [rsbst_pkg::NUM_LANES-1:0][COORD_WIDTH-1:0] den_mag,
	output rsbst_pkg::rsbst_qctl_t [rsbst_pkg::NUM_LANES-1:0] qctl,
	output rsbst_pkg::rsbst_axis_t [rsbst_pkg::NUM_AXES-1:0]  flags
);

	localparam int CW      = COORD_WIDTH;
	localparam int SAT_SHR = rsbst_pkg::MAG_W - FRACTION_BITS;

	logic [rsbst_pkg::NUM_LANES-1:0][CW:0]   diff_s1;
	logic [rsbst_pkg::NUM_AXES-1:0][CW-1:0]  den_s1;
	rsbst_pkg::rsbst_axis_t [rsbst_pkg::NUM_AXES-1:0] flags_s1;

	logic [rsbst_pkg::NUM_LANES-1:0][CW:0]   nmag_c;
	logic [rsbst_pkg::NUM_LANES-1:0][CW-1:0] dmag_c;
	rsbst_pkg::rsbst_qctl_t [rsbst_pkg::NUM_LANES-1:0] qctl_c;

	logic [rsbst_pkg::NUM_LANES-1:0][CW:0]   nmag_s2;
	logic [rsbst_pkg::NUM_LANES-1:0][CW-1:0] dmag_s2;
	rsbst_pkg::rsbst_qctl_t [rsbst_pkg::NUM_LANES-1:0] qctl_s2;
	rsbst_pkg::rsbst_axis_t [rsbst_pkg::NUM_AXES-1:0]  flags_s2;

	// Stage 1: offsets of both slab planes from the origin, slab membership
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < rsbst_pkg::NUM_AXES; a++) begin
				diff_s1[2*a]   <= $signed({box_min[a][CW-1], box_min[a]})
					- $signed({origin[a][CW-1], origin[a]});
				diff_s1[2*a+1] <= $signed({box_max[a][CW-1], box_max[a]})
					- $signed({origin[a][CW-1], origin[a]});
				den_s1[a]         <= delta[a];
				flags_s1[a].zero  <= (delta[a] == '0);
				flags_s1[a].in_slab <= ($signed(origin[a]) >= $signed(box_min[a]))
					&& ($signed(origin[a]) <= $signed(box_max[a]));
			end
		end
	end

	// Magnitudes, quotient sign and saturation test
	always_comb begin
		for (int l = 0; l < rsbst_pkg::NUM_LANES; l++) begin
			nmag_c[l] = diff_s1[l][CW] ? (~diff_s1[l] + 1'b1) : diff_s1[l];
			dmag_c[l] = den_s1[l/2][CW-1] ? (~den_s1[l/2] + 1'b1) : den_s1[l/2];
			qctl_c[l].neg = diff_s1[l][CW] ^ den_s1[l/2][CW-1];
			// whole part >= 2^(47-FB) exactly when (n >> (47-FB)) >= d
			qctl_c[l].sat = (nmag_c[l] >> SAT_SHR) >= {1'b0, dmag_c[l]};
		end
	end

	// Stage 2
	always_ff @(posedge clk) begin
		if (en) begin
			nmag_s2  <= nmag_c;
			dmag_s2  <= dmag_c;
			qctl_s2  <= qctl_c;
			flags_s2 <= flags_s1;
		end
	end

	assign num_mag = nmag_s2;
	assign den_mag = dmag_s2;
	assign qctl    = qctl_s2;
	assign flags   = flags_s2;

endmodule

// File: design/rsbst_div_stage.sv
// One registered stage of the restoring divider: STEPS quotient bits.
// Depends on rsbst_pkg.
module rsbst_div_stage #(
	parameter int COORD_WIDTH = 32,
	parameter int DVD_W       = 49,
	parameter int STEPS       = 2
) (
	input  logic clk,
	input  logic en,
	input  logic [COORD_WIDTH-1:0] rem_in,
	input  logic [DVD_W-1:0]       dvd_in,
	input  logic [COORD_WIDTH-1:0] den_in,
	input  rsbst_pkg::rsbst_qctl_t qctl_in,
	output logic [COORD_WIDTH-1:0] rem_out,
	output logic [DVD_W-1:0]       dvd_out,
	output logic [COORD_WIDTH-1:0] den_out,
	output rsbst_pkg::rsbst_qctl_t qctl_out
);

	localparam int CW = COORD_WIDTH;

	logic [CW-1:0]    rem_c;
	logic [DVD_W-1:0] dvd_c;

	// Shift in the next dividend bit, subtract when it fits; quotient
	// bits replace dividend bits from the bottom.
	always_comb begin
		logic [CW:0] part;
		logic        qbit;
		rem_c = rem_in;
		dvd_c = dvd_in;
		for (int i = 0; i < STEPS; i++) begin
			part = {rem_c, dvd_c[DVD_W-1]};
			qbit = (part >= {1'b0, den_in});
			if (qbit) begin
				part = part - {1'b0, den_in};
			end
			rem_c = part[CW-1:0];
			dvd_c = {dvd_c[DVD_W-2:0], qbit};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out  <= rem_c;
			dvd_out  <= dvd_c;
			den_out  <= den_in;
			qctl_out <= qctl_in;
		end
	end

endmodule

// File: design/rsbst_divider.sv
// Pipelined unsigned divider: (num << FB) / den; two quotient bits per stage, the last may take one.
// Depends on rsbst_pkg and rsbst_div_stage.
module rsbst_divider #(
	parameter int COORD_WIDTH   = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic clk,
	input  logic en,
	input  logic [COORD_WIDTH:0]   num,
	input  logic [COORD_WIDTH-1:0] den,
	input  rsbst_pkg::rsbst_qctl_t qctl_in,
	output logic [rsbst_pkg::MAG_W-1:0] quo,
	output rsbst_pkg::rsbst_qctl_t qctl_out
);

	localparam int CW    = COORD_WIDTH;
	localparam int DVD_W = CW + 1 + FRACTION_BITS;
	localparam int NSTG  = (DVD_W + 1) / 2;

	logic [NSTG:0][CW-1:0]    rem_w;
	logic [NSTG:0][DVD_W-1:0] dvd_w;
	logic [NSTG:0][CW-1:0]    den_w;
	rsbst_pkg::rsbst_qctl_t [NSTG:0] qctl_w;

	assign rem_w[0]  = '0;
	assign dvd_w[0]  = {num, {FRACTION_BITS{1'b0}}};
	assign den_w[0]  = den;
	assign qctl_w[0] = qctl_in;

	for (genvar k = 0; k < NSTG; k++) begin : g_stage
		localparam int STEPS = ((DVD_W - 2 * k) >= 2) ? 2 : 1;
		rsbst_div_stage #(
			.COORD_WIDTH(CW),
			.DVD_W      (DVD_W),
			.STEPS      (STEPS)
		) u_stage (
			.clk     (clk),
			.en      (en),
			.rem_in  (rem_w[k]),
			.dvd_in  (dvd_w[k]),
			.den_in  (den_w[k]),
			.qctl_in (qctl_w[k]),
			.rem_out (rem_w[k+1]),
			.dvd_out (dvd_w[k+1]),
			.den_out (den_w[k+1]),
			.qctl_out(qctl_w[k+1])
		);
	end

	// Quotient is below 2^47 whenever it is not saturated
	if (DVD_W >= rsbst_pkg::MAG_W) begin : g_trunc
		assign quo = dvd_w[NSTG][rsbst_pkg::MAG_W-1:0];
	end else begin : g_ext
		assign quo = {{(rsbst_pkg::MAG_W - DVD_W){1'b0}}, dvd_w[NSTG]};
	end

	assign qctl_out = qctl_w[NSTG];

endmodule

// File: design/rsbst_merge.sv
// Back end: signed t values, per-axis ordering, interval narrowing, hit.
// Depends on rsbst_pkg.
module rsbst_merge #(
	parameter int FRACTION_BITS = 16
) (
	input  logic clk,
	input  logic en,
	input  logic [rsbst_pkg::NUM_LANES-1:0][rsbst_pkg::MAG_W-1:0] quo,
	input  rsbst_pkg::rsbst_qctl_t [rsbst_pkg::NUM_LANES-1:0] qctl,
	input  rsbst_pkg::rsbst_axis_t [rsbst_pkg::NUM_AXES-1:0]  flags,
	output logic hit
);

	localparam int TW = rsbst_pkg::T_W;
	localparam logic [TW-1:0] T_ONE = TW'(1) << FRACTION_BITS;

	logic [rsbst_pkg::NUM_LANES-1:0][TW-1:0] t_s1;
	rsbst_pkg::rsbst_axis_t [rsbst_pkg::NUM_AXES-1:0] flags_s1;
	logic [rsbst_pkg::NUM_AXES-1:0][TW-1:0] tlo_s2;
	logic [rsbst_pkg::NUM_AXES-1:0][TW-1:0] thi_s2;
	rsbst_pkg::rsbst_axis_t [rsbst_pkg::NUM_AXES-1:0] flags_s2;
	logic hit_c;
	logic hit_s3;

	// Stage 1: apply sign or saturation
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < rsbst_pkg::NUM_LANES; l++) begin
				if (qctl[l].sat) begin
					t_s1[l] <= qctl[l].neg ? rsbst_pkg::T_SAT_NEG : rsbst_pkg::T_SAT_POS;
				end else if (qctl[l].neg) begin
					t_s1[l] <= ~{1'b0, quo[l]} + 1'b1;
				end else begin
					t_s1[l] <= {1'b0, quo[l]};
				end
			end
			flags_s1 <= flags;
		end
	end

	// Stage 2: order entry and exit per axis
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < rsbst_pkg::NUM_AXES; a++) begin
				if ($signed(t_s1[2*a]) > $signed(t_s1[2*a+1])) begin
					tlo_s2[a] <= t_s1[2*a+1];
					thi_s2[a] <= t_s1[2*a];
				end else begin
					tlo_s2[a] <= t_s1[2*a];
					thi_s2[a] <= t_s1[2*a+1];
				end
			end
			flags_s2 <= flags_s1;
		end
	end

	// Narrow [0,1] over the non-degenerate axes; zero-direction axes need the origin in the slab
	always_comb begin
		logic [TW-1:0] tmin;
		logic [TW-1:0] tmax;
		logic          ok;
		tmin = '0;
		tmax = T_ONE;
		ok   = 1'b1;
		for (int a = 0; a < rsbst_pkg::NUM_AXES; a++) begin
			if (flags_s2[a].zero) begin
				ok = ok & flags_s2[a].in_slab;
			end else begin
				if ($signed(tlo_s2[a]) > $signed(tmin)) begin
					tmin = tlo_s2[a];
				end
				if ($signed(thi_s2[a]) < $signed(tmax)) begin
					tmax = thi_s2[a];
				end
			end
		end
		hit_c = ok && ($signed(tmin) <= $signed(tmax));
	end

	// Stage 3: result register
	always_ff @(posedge clk) begin
		if (en) begin
			hit_s3 <= hit_c;
		end
	end

	assign hit = hit_s3;

endmodule

// File: design/ray_segment_box_slab_test.sv
// Segment versus axis-aligned box test (slab method), fully pipelined.
// Depends on rsbst_pkg, rsbst_prep, rsbst_divider, rsbst_merge.
//
// Channel | Dir | tdata fields (lowest bits first)                     | Other
// s_      | in  | origin xyz, delta xyz, box_min xyz, box_max xyz     | tvalid/tready
// m_      | out | hit, then zero padding to 8 bits                   | tvalid/tready
//
// One transaction accepted per cycle while the output does not stall; results pass
// through the prep, divider and merge stages, the six divider pipelines side by side.
// Reset clears only the valid bits; the datapath needs none.
// A stall on the output freezes the whole pipeline; s_tready follows it.
module ray_segment_box_slab_test #(
	parameter  int COORD_WIDTH   = 32,
	parameter  int FRACTION_BITS = 16,
	localparam int S_DATA_W      = ((12 * COORD_WIDTH + 7) / 8) * 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // origin_x..z, delta_x..z, box_min_x..z, box_max_x..z
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [rsbst_pkg::OUT_W-1:0] m_tdata  // hit, zero padding
);

	localparam int CW    = COORD_WIDTH;
	localparam int DVD_W = CW + 1 + FRACTION_BITS;
	localparam int NSTG  = (DVD_W + 1) / 2;
	localparam int LAT   = 2 + NSTG + 3;

	logic en;
	logic [LAT-1:0] vld_q;

	logic [rsbst_pkg::NUM_AXES-1:0][CW-1:0] origin, delta, box_min, box_max;
	logic [rsbst_pkg::NUM_LANES-1:0][CW:0]   num_mag;
	logic [rsbst_pkg::NUM_LANES-1:0][CW-1:0] den_mag;
	rsbst_pkg::rsbst_qctl_t [rsbst_pkg::NUM_LANES-1:0] qctl_pre, qctl_post;
	logic [rsbst_pkg::NUM_LANES-1:0][rsbst_pkg::MAG_W-1:0] quo;
	rsbst_pkg::rsbst_axis_t [rsbst_pkg::NUM_AXES-1:0] flags_pre;
	rsbst_pkg::rsbst_axis_t [rsbst_pkg::NUM_AXES-1:0] flags_q [NSTG];
	logic hit;

	// Global advance: move whenever the output slot is free or drains
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];
	assign m_tdata  = {{(rsbst_pkg::OUT_W - 1){1'b0}}, hit};

	// Unpack the input transaction
	for (genvar a = 0; a < rsbst_pkg::NUM_AXES; a++) begin : g_unpack
		assign origin[a]  = s_tdata[a * CW +: CW];
		assign delta[a]   = s_tdata[(3 + a) * CW +: CW];
		assign box_min[a] = s_tdata[(6 + a) * CW +: CW];
		assign box_max[a] = s_tdata[(9 + a) * CW +: CW];
	end

	// Valid bits alongside the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	rsbst_prep #(
		.COORD_WIDTH  (CW),
		.FRACTION_BITS(FRACTION_BITS)
	) u_prep (
		.clk    (clk),
		.en     (en),
		.origin (origin),
		.delta  (delta),
		.box_min(box_min),
		.box_max(box_max),
		.num_mag(num_mag),
		.den_mag(den_mag),
		.qctl   (qctl_pre),
		.flags  (flags_pre)
	);

	for (genvar l = 0; l < rsbst_pkg::NUM_LANES; l++) begin : g_div
		rsbst_divider #(
			.COORD_WIDTH  (CW),
			.FRACTION_BITS(FRACTION_BITS)
		) u_div (
			.clk     (clk),
			.en      (en),
			.num     (num_mag[l]),
			.den     (den_mag[l]),
			.qctl_in (qctl_pre[l]),
			.quo     (quo[l]),
			.qctl_out(qctl_post[l])
		);
	end

	// Axis flags wait out the divider latency
	always_ff @(posedge clk) begin
		if (en) begin
			flags_q[0] <= flags_pre;
			for (int k = 1; k < NSTG; k++) begin
				flags_q[k] <= flags_q[k-1];
			end
		end
	end

	rsbst_merge #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_merge (
		.clk  (clk),
		.en   (en),
		.quo  (quo),
		.qctl (qctl_post),
		.flags(flags_q[NSTG-1]),
		.hit  (hit)
	);

endmodule

// File: design/rsbst_checker.sv
// Port-level checks for the segment/box slab tester, bound to the top level.
// Depends on ray_segment_box_slab_test_defines.svh.
`include "ray_segment_box_slab_test_defines.svh"

module rsbst_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	// A stalled result holds
	`RSB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// Empty output slot never blocks the input
	`RSB_ASSERT_IMP(a_ready_when_empty, !m_tvalid, s_tready)
	// Input stalls only because the output stalls
	`RSB_ASSERT_IMP(a_ready_when_drain, m_tready, s_tready)
	// Padding above hit stays clear
	`RSB_ASSERT_IMP(a_pad_zero, m_tvalid, m_tdata[7:1] == 7'd0)

endmodule

bind ray_segment_box_slab_test rsbst_checker u_rsbst_checker (.*);
